[rtl/sensor_frame_builder_with_alarm_throttle_top_macros.svh]
// ----------------------------------------------------------------------------
// sensor frame builder assertion macros
// shared concurrent assertion forms, compiled out with NO_ASSERTIONS
// ----------------------------------------------------------------------------
`ifndef SENSOR_FRAME_BUILDER_WITH_ALARM_THROTTLE_TOP_MACROS_SVH
`define SENSOR_FRAME_BUILDER_WITH_ALARM_THROTTLE_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define SFB_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SFB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define SFB_ASSERT_SAME(lbl, ante, cons, msg)
`define SFB_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

[rtl/sfb_pkg.sv]
// ----------------------------------------------------------------------------
// sfb_pkg
// shared types, codes and constants of the sensor frame builder
// ----------------------------------------------------------------------------
package sfb_pkg;

    // default identifier bases
    localparam int EMERGENCY_BASE_DEF = 256;
    localparam int NORMAL_BASE_DEF    = 512;
    localparam int LOWFREQ_BASE_DEF   = 768;

    // event kinds
    localparam logic [2:0] MODE_HEARTBEAT = 3'd0;
    localparam logic [2:0] MODE_TEMP_HUMI = 3'd1;
    localparam logic [2:0] MODE_LIGHT     = 3'd2;
    localparam logic [2:0] MODE_ALARM     = 3'd3;
    localparam logic [2:0] MODE_RECOVER   = 3'd4;

    // register indexes
    localparam logic [2:0] REG_NODE_NUMBER    = 3'd0;
    localparam logic [2:0] REG_CODE_HEARTBEAT = 3'd1;
    localparam logic [2:0] REG_CODE_TEMP_HUMI = 3'd2;
    localparam logic [2:0] REG_CODE_LIGHT     = 3'd3;
    localparam logic [2:0] REG_CODE_ALARM     = 3'd4;
    localparam logic [2:0] REG_CODE_RECOVER   = 3'd5;

    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 32;

    // throttle constants
    localparam logic [31:0] GAP_RESET_MS     = 32'd5000;
    localparam logic [31:0] SLOW_INTERVAL_MS = 32'd2000;
    localparam logic [31:0] FAST_INTERVAL_MS = 32'd1000;
    localparam logic [7:0]  RUN_SLOW_AT      = 8'd5;
    localparam logic [7:0]  RUN_MAX          = 8'd250;
    localparam logic [15:0] DROP_MAX         = 16'hFFFF;

    // frame bytes
    localparam logic [7:0] ALARM_FLAG_BYTE = 8'h01;
    localparam logic [7:0] FTYPE_EMERGENCY = 8'd0;
    localparam logic [7:0] FTYPE_NORMAL    = 8'd1;
    localparam logic [7:0] FTYPE_LOWFREQ   = 8'd2;

    typedef struct packed {
        logic [2:0]  mode;
        logic [31:0] now_ms;
        logic [7:0]  temp_whole;
        logic [7:0]  temp_frac;
        logic [7:0]  humi_whole;
        logic [7:0]  humi_frac;
        logic [15:0] lux_level;
    } sfb_in_t;

    typedef struct packed {
        logic        frame_valid;
        logic [10:0] can_ident;
        logic [63:0] frame_bytes;
        logic [15:0] dropped_alarms;
    } sfb_out_t;

    typedef struct packed {
        logic [7:0] node_number;
        logic [7:0] code_heartbeat;
        logic [7:0] code_temp_humi;
        logic [7:0] code_light;
        logic [7:0] code_alarm;
        logic [7:0] code_recover;
    } sfb_cfg_t;

    typedef struct packed {
        logic        drop;
        logic [15:0] dropped_alarms;
    } sfb_thr_t;

endpackage

[rtl/sensor_frame_builder_with_alarm_throttle_top.sv]
// ----------------------------------------------------------------------------
// sensor_frame_builder_with_alarm_throttle_top
// builds one eight-byte can frame per sensor event, rate-limits alarms
// ----------------------------------------------------------------------------
//  channel   direction  handshake              payload
//  in        input      in_valid / in_stall    in_data  (sfb_in_t)
//  out       output     out_valid / out_stall  out_data (sfb_out_t)
//  cfg       apb        psel / penable / pready paddr, pwdata, prdata
//
//  one request per cycle sustained while out_stall is low
//  the rate is set by the throttle update in the advance path
//  an input register and a result register part the two sides, so one more
//  request is taken while a finished result waits under out_stall
//  rst_n clears valids, throttle state and config registers at once; no clearing pass
// ----------------------------------------------------------------------------
`include "sensor_frame_builder_with_alarm_throttle_top_macros.svh"

module sensor_frame_builder_with_alarm_throttle_top
#(
    parameter int EMERGENCY_BASE = sfb_pkg::EMERGENCY_BASE_DEF,
    parameter int NORMAL_BASE    = sfb_pkg::NORMAL_BASE_DEF,
    parameter int LOWFREQ_BASE   = sfb_pkg::LOWFREQ_BASE_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    // configuration port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [sfb_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [sfb_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [sfb_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready,
    // event requests
    input  logic                           in_valid,
    output logic                           in_stall,
    input  sfb_pkg::sfb_in_t               in_data,
    // frame results
    output logic                           out_valid,
    input  logic                           out_stall,
    output sfb_pkg::sfb_out_t              out_data
);

    sfb_pkg::sfb_cfg_t cfg;
    sfb_pkg::sfb_thr_t thr;
    sfb_pkg::sfb_out_t result;

    // input register
    logic              s1_valid_reg;
    logic              s1_valid_next;
    sfb_pkg::sfb_in_t  s1_data_reg;

    // result register
    logic              out_valid_reg;
    logic              out_valid_next;
    sfb_pkg::sfb_out_t out_data_reg;

    logic              out_free;
    logic              s1_adv;
    logic              in_acc;

    // result slot is free when empty or being taken this cycle
    assign out_free = !out_valid_reg || !out_stall;
    assign s1_adv   = s1_valid_reg && out_free;
    assign in_stall = s1_valid_reg && !out_free;
    assign in_acc   = in_valid && !in_stall;

    assign s1_valid_next  = in_acc ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_reg);
    assign out_valid_next = s1_adv ? 1'b1 : (out_free ? 1'b0 : out_valid_reg);

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    sfb_cfg_regs u_cfg_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // throttle state moves only when the request leaves the input register
    sfb_alarm_throttle u_throttle
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .is_alarm (s1_data_reg.mode == sfb_pkg::MODE_ALARM),
        .load     (s1_adv),
        .now_ms   (s1_data_reg.now_ms),
        .status   (thr)
    );

    sfb_frame_pack
    #(
        .EMERGENCY_BASE (EMERGENCY_BASE),
        .NORMAL_BASE    (NORMAL_BASE),
        .LOWFREQ_BASE   (LOWFREQ_BASE)
    )
    u_frame_pack
    (
        .item   (s1_data_reg),
        .cfg    (cfg),
        .thr    (thr),
        .result (result)
    );

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_data_reg <= in_data;
        end
        if (s1_adv)
        begin
            out_data_reg <= result;
        end
    end

    // a dropped alarm carries no identifier and no bytes
    `SFB_ASSERT_SAME(a_drop_clean, out_valid_reg && !out_data_reg.frame_valid,
        out_data_reg.can_ident == 11'd0 && out_data_reg.frame_bytes == 64'd0,
        "dropped alarm with frame content")

    // checksum byte closes the xor over all eight bytes
    `SFB_ASSERT_SAME(a_checksum, out_valid_reg && out_data_reg.frame_valid,
        (out_data_reg.frame_bytes[7:0] ^ out_data_reg.frame_bytes[15:8]
         ^ out_data_reg.frame_bytes[23:16] ^ out_data_reg.frame_bytes[31:24]
         ^ out_data_reg.frame_bytes[39:32] ^ out_data_reg.frame_bytes[47:40]
         ^ out_data_reg.frame_bytes[55:48] ^ out_data_reg.frame_bytes[63:56]) == 8'h00,
        "frame checksum mismatch")

    // drop count never falls from one result to the next
    `SFB_ASSERT_NEXT(a_drop_mono, out_valid_reg && !out_stall,
        !out_valid_reg || out_data_reg.dropped_alarms >= $past(out_data_reg.dropped_alarms),
        "drop count decreased")

    // an advancing request always lands in the result register
    `SFB_ASSERT_NEXT(a_advance, s1_valid_reg && out_free, out_valid_reg,
        "advanced request lost")

endmodule

[rtl/sfb_cfg_regs.sv]
// ----------------------------------------------------------------------------
// sfb_cfg_regs
// apb register bank holding node number and function codes
// ----------------------------------------------------------------------------
module sfb_cfg_regs
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [sfb_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [sfb_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [sfb_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready,
    output sfb_pkg::sfb_cfg_t              cfg
);

    sfb_pkg::sfb_cfg_t cfg_reg;
    sfb_pkg::sfb_cfg_t cfg_next;
    logic [2:0]        reg_index;
    logic              wr_en;
    logic [7:0]        rd_byte;

    assign pready    = 1'b1;
    assign reg_index = paddr[4:2];
    assign wr_en     = psel && penable && pwrite;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_index)
                sfb_pkg::REG_NODE_NUMBER:    cfg_next.node_number    = pwdata[7:0];
                sfb_pkg::REG_CODE_HEARTBEAT: cfg_next.code_heartbeat = pwdata[7:0];
                sfb_pkg::REG_CODE_TEMP_HUMI: cfg_next.code_temp_humi = pwdata[7:0];
                sfb_pkg::REG_CODE_LIGHT:     cfg_next.code_light     = pwdata[7:0];
                sfb_pkg::REG_CODE_ALARM:     cfg_next.code_alarm     = pwdata[7:0];
                sfb_pkg::REG_CODE_RECOVER:   cfg_next.code_recover   = pwdata[7:0];
                default:                     cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_index)
            sfb_pkg::REG_NODE_NUMBER:    rd_byte = cfg_reg.node_number;
            sfb_pkg::REG_CODE_HEARTBEAT: rd_byte = cfg_reg.code_heartbeat;
            sfb_pkg::REG_CODE_TEMP_HUMI: rd_byte = cfg_reg.code_temp_humi;
            sfb_pkg::REG_CODE_LIGHT:     rd_byte = cfg_reg.code_light;
            sfb_pkg::REG_CODE_ALARM:     rd_byte = cfg_reg.code_alarm;
            sfb_pkg::REG_CODE_RECOVER:   rd_byte = cfg_reg.code_recover;
            default:                     rd_byte = 8'd0;
        endcase
    end

    assign prdata = {{(sfb_pkg::CFG_DATA_W-8){1'b0}}, rd_byte};
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.node_number    <= 8'd1;
            cfg_reg.code_heartbeat <= 8'd1;
            cfg_reg.code_temp_humi <= 8'd2;
            cfg_reg.code_light     <= 8'd3;
            cfg_reg.code_alarm     <= 8'd4;
            cfg_reg.code_recover   <= 8'd5;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

[rtl/sfb_alarm_throttle.sv]
// ----------------------------------------------------------------------------
// sfb_alarm_throttle
// alarm rate limiter with run count and saturating drop counter
// ----------------------------------------------------------------------------
module sfb_alarm_throttle
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              is_alarm,
    input  logic              load,
    input  logic [31:0]       now_ms,
    output sfb_pkg::sfb_thr_t status
);

    logic [31:0] last_time_reg;
    logic [7:0]  run_count_reg;
    logic [15:0] drop_total_reg;
    logic [31:0] gap;
    logic [7:0]  run_eff;
    logic [31:0] interval;
    logic        too_soon;
    logic [15:0] drop_next;
    logic [7:0]  run_next;

    // wrapping difference since the last sent alarm
    assign gap       = now_ms - last_time_reg;
    assign run_eff   = (gap > sfb_pkg::GAP_RESET_MS) ? 8'd0 : run_count_reg;
    assign interval  = (run_eff >= sfb_pkg::RUN_SLOW_AT) ? sfb_pkg::SLOW_INTERVAL_MS
                                                         : sfb_pkg::FAST_INTERVAL_MS;
    assign too_soon  = gap < interval;
    assign drop_next = (drop_total_reg != sfb_pkg::DROP_MAX) ? drop_total_reg + 16'd1
                                                             : drop_total_reg;
    assign run_next  = (run_eff < sfb_pkg::RUN_MAX) ? run_eff + 8'd1 : run_eff;

    assign status.drop           = is_alarm && too_soon;
    assign status.dropped_alarms = (is_alarm && too_soon) ? drop_next : drop_total_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_time_reg  <= 32'd0;
            run_count_reg  <= 8'd0;
            drop_total_reg <= 16'd0;
        end
        else if (load && is_alarm)
        begin
            if (too_soon)
            begin
                drop_total_reg <= drop_next;
                run_count_reg  <= run_eff;
            end
            else
            begin
                last_time_reg <= now_ms;
                run_count_reg <= run_next;
            end
        end
    end

endmodule

[rtl/sfb_frame_pack.sv]
// ----------------------------------------------------------------------------
// sfb_frame_pack
// identifier selection, frame type, payload bytes and checksum
// ----------------------------------------------------------------------------
module sfb_frame_pack
#(
    parameter int EMERGENCY_BASE = sfb_pkg::EMERGENCY_BASE_DEF,
    parameter int NORMAL_BASE    = sfb_pkg::NORMAL_BASE_DEF,
    parameter int LOWFREQ_BASE   = sfb_pkg::LOWFREQ_BASE_DEF
)
(
    input  sfb_pkg::sfb_in_t  item,
    input  sfb_pkg::sfb_cfg_t cfg,
    input  sfb_pkg::sfb_thr_t thr,
    output sfb_pkg::sfb_out_t result
);

    localparam logic [10:0] EMERG_ID = 11'(EMERGENCY_BASE);
    localparam logic [10:0] NORM_ID  = 11'(NORMAL_BASE);
    localparam logic [10:0] LOWF_ID  = 11'(LOWFREQ_BASE);

    logic [10:0] ident;
    logic [7:0]  func;
    logic [7:0]  ftype;
    logic [7:0]  pb3;
    logic [7:0]  pb4;
    logic [7:0]  pb5;
    logic [7:0]  pb6;
    logic [7:0]  csum;

    always_comb
    begin
        ident = NORM_ID;
        func  = cfg.code_heartbeat;
        pb3   = cfg.node_number;
        pb4   = 8'd0;
        pb5   = 8'd0;
        pb6   = 8'd0;
        unique case (item.mode)
            sfb_pkg::MODE_ALARM:
            begin
                ident = EMERG_ID;
                func  = cfg.code_alarm;
                pb4   = sfb_pkg::ALARM_FLAG_BYTE;
            end
            sfb_pkg::MODE_TEMP_HUMI:
            begin
                func = cfg.code_temp_humi;
                pb3  = item.temp_whole;
                pb4  = item.temp_frac;
                pb5  = item.humi_whole;
                pb6  = item.humi_frac;
            end
            sfb_pkg::MODE_LIGHT:
            begin
                // wraps modulo 2^11
                ident = LOWF_ID + {3'd0, cfg.node_number};
                func  = cfg.code_light;
                pb3   = item.lux_level[15:8];
                pb4   = item.lux_level[7:0];
            end
            sfb_pkg::MODE_RECOVER:
            begin
                func = cfg.code_recover;
            end
            default:
            begin
                func = cfg.code_heartbeat;
            end
        endcase
    end

    always_comb
    begin
        priority if (ident >= EMERG_ID && ident < NORM_ID)
            ftype = sfb_pkg::FTYPE_EMERGENCY;
        else if (ident >= LOWF_ID)
            ftype = sfb_pkg::FTYPE_LOWFREQ;
        else
            ftype = sfb_pkg::FTYPE_NORMAL;
    end

    assign csum = ftype ^ cfg.node_number ^ func ^ pb3 ^ pb4 ^ pb5 ^ pb6;

    always_comb
    begin
        result.dropped_alarms = thr.dropped_alarms;
        if (thr.drop)
        begin
            result.frame_valid = 1'b0;
            result.can_ident   = 11'd0;
            result.frame_bytes = 64'd0;
        end
        else
        begin
            result.frame_valid = 1'b1;
            result.can_ident   = ident;
            result.frame_bytes = {csum, pb6, pb5, pb4, pb3, func, cfg.node_number, ftype};
        end
    end

endmodule
